### rtl/core/rpp_pkg.sv
// rpp_pkg: shared types, constants and the square root step for the radius pick block
// depends on nothing
`default_nettype none
package rpp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int RES_CAP        = 64;
  localparam int CNT_W          = $clog2(RES_CAP + 1);
  localparam int COORD_W        = 24;
  localparam int DIST_W         = 24;
  localparam int HIDX_W         = 6;
  localparam int SQ_W           = 51;
  localparam int SQRT_CYCLES    = 13;
  localparam int SQRT_CNT_W     = $clog2(SQRT_CYCLES);
  localparam logic [DIST_W-1:0] RADIUS_RESET = 24'd2560;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [5:0]                entry_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic                      entry_present;
    logic                      entry_interactable;
    logic                      entry_visible;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [HIDX_W-1:0] hit_index;
    logic [DIST_W-1:0] hit_distance;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_SQRT,
    ST_INS,
    ST_EMIT
  } state_t;

  // control from the sequencer to the sorted hit list
  typedef struct packed {
    logic clr;
    logic ins;
    logic pop;
  } list_ctl_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    logic [SQ_W-1:0] bitv;
  } sqrt_t;

  // one bit of a restoring integer square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t           o;
    logic [SQ_W-1:0] trial;
    o     = s;
    trial = s.root + s.bitv;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + s.bitv;
    end else begin
      o.root = s.root >> 1;
    end
    o.bitv = s.bitv >> 2;
    return o;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rpp_ram.sv
// rpp_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none
module rpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/rpp_sort.sv
// rpp_sort: sorted hit list, a row of compare-and-shift cells ordered by distance
// depends on rpp_pkg
`default_nettype none
module rpp_sort import rpp_pkg::*; #(
  parameter int IDX_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire list_ctl_t         ctl,
  input  wire logic [IDX_W-1:0]  ins_idx,
  input  wire logic [DIST_W-1:0] ins_dist,
  output logic      [IDX_W-1:0]  head_idx,
  output logic      [DIST_W-1:0] head_dist,
  output logic      [CNT_W-1:0]  count
);

  logic                valid_r [RES_CAP];
  logic [IDX_W-1:0]    idx_r   [RES_CAP];
  logic [DIST_W-1:0]   dist_r  [RES_CAP];
  logic [RES_CAP-1:0]  ins_pos;
  logic [CNT_W-1:0]    count_r;

  // equal distances stay ahead of the new hit
  always_comb begin
    for (int k = 0; k < RES_CAP; k++) begin
      ins_pos[k] = !valid_r[k] || (dist_r[k] > ins_dist);
    end
  end

  for (genvar k = 0; k < RES_CAP; k++) begin : g_cell
    logic take_new;
    logic take_prev;
    if (k == 0) begin : g_first
      assign take_new  = ins_pos[k];
      assign take_prev = 1'b0;
    end else begin : g_rest
      assign take_new  = ins_pos[k] && !ins_pos[k-1];
      assign take_prev = ins_pos[k] && ins_pos[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n || ctl.clr) begin
        valid_r[k] <= 1'b0;
      end else if (ctl.ins) begin
        if (take_new) begin
          valid_r[k] <= 1'b1;
        end else if (take_prev) begin
          valid_r[k] <= valid_r[(k > 0) ? k-1 : 0];
        end
      end else if (ctl.pop) begin
        valid_r[k] <= (k < RES_CAP-1) ? valid_r[(k < RES_CAP-1) ? k+1 : k] : 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.ins) begin
        if (take_new) begin
          idx_r[k]  <= ins_idx;
          dist_r[k] <= ins_dist;
        end else if (take_prev) begin
          idx_r[k]  <= idx_r[(k > 0) ? k-1 : 0];
          dist_r[k] <= dist_r[(k > 0) ? k-1 : 0];
        end
      end else if (ctl.pop && k < RES_CAP-1) begin
        idx_r[k]  <= idx_r[(k < RES_CAP-1) ? k+1 : k];
        dist_r[k] <= dist_r[(k < RES_CAP-1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      count_r <= '0;
    end else if (ctl.ins && count_r < CNT_W'(RES_CAP)) begin
      count_r <= count_r + 1'b1;
    end else if (ctl.pop && count_r != '0) begin
      count_r <= count_r - 1'b1;
    end
  end

  assign head_idx  = idx_r[0];
  assign head_dist = dist_r[0];
  assign count     = count_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RES_CAP))
    else $error("hit count above cap");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.ins && !ctl.clr && count_r < CNT_W'(RES_CAP)) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow list");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[1] |-> (valid_r[0] && dist_r[0] <= dist_r[1]))
    else $error("hit list out of order");

endmodule
`default_nettype wire

### rtl/core/radius_point_pick_sorted.sv
// radius_point_pick_sorted: fixed radius point pick over a point table, hits sorted by distance
// depends on rpp_pkg, rpp_ram, rpp_sort
`default_nettype none
//
//  channel  dir  payload      handshake
//  in_      in   in_word_t    in_valid / in_ready
//  out_     out  out_word_t   out_valid / out_ready
//  cfg_     in   pick radius  cfg_valid / cfg_ready
//
//  a write word goes straight into the table as it is accepted
//  a query visits each table entry in a scan and a sum state, and each hit adds the
//  two-bit-per-cycle square root and the sorted insert, then the result words follow
//  a query with no hits gives a single result word with found low and last set
//  after reset a clearing pass zeroes the table before in_ready rises
//  a stalled out_ready holds the result register and the query waits on it
module radius_point_pick_sorted import rpp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DIST_W-1:0] cfg_data
);

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int RAM_W = 2 * COORD_W + 1;

  // sequencer state
  state_t                 state_r, state_nxt;
  logic [IW-1:0]          scan_r, scan_nxt;
  logic [SQRT_CNT_W-1:0]  cnt_r, cnt_nxt;
  sqrt_t                  sq_r, sq_nxt;

  // query position and radius
  logic signed [COORD_W-1:0] qx_r, qx_nxt;
  logic signed [COORD_W-1:0] qy_r, qy_nxt;
  logic [DIST_W-1:0]         radius_r;
  logic [SQ_W-1:0]           thr_r;
  logic [DIST_W:0]           r_plus;
  logic [2*DIST_W+1:0]       thr_prod;

  // squared offsets of the entry under scan
  logic [2*COORD_W+1:0] sqx_r, sqy_r;
  logic                 en_r;
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        adx, ady;
  logic [SQ_W-1:0]         sum;

  // table ram: x, y and the combined pick flag
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;
  logic               idx_ok;
  logic               in_acc;
  logic               scan_end;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  list_ctl_t          list_ctl;
  logic [IW-1:0]      head_idx;
  logic [DIST_W-1:0]  head_dist;
  logic [CNT_W-1:0]   hit_count;

  rpp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_nxt),
    .rdata (ram_rdata)
  );

  rpp_sort #(
    .IDX_W (IW)
  ) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (list_ctl),
    .ins_idx   (scan_r),
    .ins_dist  (sq_r.root[DIST_W-1:0]),
    .head_idx  (head_idx),
    .head_dist (head_dist),
    .count     (hit_count)
  );

  // radius register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  // d <= r exactly when d*d sum < (r+1)^2, so only hits need the root
  assign r_plus   = {1'b0, radius_r} + 1'b1;
  assign thr_prod = r_plus * r_plus;

  always_ff @(posedge clk) begin
    thr_r <= SQ_W'(thr_prod);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign idx_ok   = (32'(in_data.entry_index) < 32'(MAX_POINTS));
  assign scan_end = (scan_r == IW'(MAX_POINTS - 1));

  // offsets of the entry read last cycle
  assign dx  = {ram_rdata[RAM_W-1], ram_rdata[RAM_W-1 -: COORD_W]} - {qx_r[COORD_W-1], qx_r};
  assign dy  = {ram_rdata[COORD_W], ram_rdata[COORD_W -: COORD_W]} - {qy_r[COORD_W-1], qy_r};
  assign adx = dx[COORD_W] ? (COORD_W+1)'(0) - dx : dx;
  assign ady = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
  assign sum = SQ_W'(sqx_r) + SQ_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      sqx_r <= adx * adx;
      sqy_r <= ady * ady;
      en_r  <= ram_rdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    sq_r       <= sq_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    ram_we        = 1'b0;
    ram_waddr     = scan_r;
    ram_wdata     = '0;
    list_ctl      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
        if (scan_end) begin
          scan_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_IDLE: begin
        scan_nxt = '0;
        if (in_acc && in_data.req_type == REQ_WRITE) begin
          ram_we    = idx_ok;
          ram_waddr = IW'(in_data.entry_index);
          ram_wdata = {in_data.coord_x, in_data.coord_y,
                       in_data.entry_present & in_data.entry_interactable
                       & in_data.entry_visible};
        end else if (in_acc) begin
          qx_nxt       = in_data.coord_x;
          qy_nxt       = in_data.coord_y;
          list_ctl.clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (en_r && sum < thr_r) begin
          sq_nxt.rem  = sum;
          sq_nxt.root = '0;
          sq_nxt.bitv = SQ_W'(1) << (SQ_W - 1);
          cnt_nxt     = '0;
          state_nxt   = ST_SQRT;
        end else if (scan_end) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SQRT: begin
        sq_nxt  = sqrt_step(sqrt_step(sq_r));
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_CYCLES - 1)) begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        list_ctl.ins = 1'b1;
        if (scan_end) begin
          state_nxt = ST_EMIT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT: begin
        // result register free or draining this cycle
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (hit_count == '0) begin
            out_data_nxt = '{found: 1'b0, hit_index: '0, hit_distance: '0, last: 1'b1};
            state_nxt    = ST_IDLE;
          end else begin
            out_data_nxt = '{found: 1'b1, hit_index: HIDX_W'(head_idx),
                             hit_distance: head_dist,
                             last: (hit_count == CNT_W'(1))};
            list_ctl.pop = 1'b1;
            if (hit_count == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |-> out_data_r.last)
    else $error("empty result without last");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_CLR) |-> !ram_we)
    else $error("table written during a query");

  a_hit_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS) |-> (sq_r.root <= SQ_W'(radius_r)))
    else $error("hit beyond pick radius");

endmodule
`default_nettype wire

### bench/tb_radius_point_pick_sorted.sv
// tb_radius_point_pick_sorted: self-checking bench for the sorted radius point pick
// depends on rpp_pkg and radius_point_pick_sorted
`timescale 1ns / 1ps
module tb_radius_point_pick_sorted;
  import rpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int NUM_RANDOM     = 231;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_word_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DIST_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  radius_point_pick_sorted u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // shadow copy of the point table and the radius register
  logic signed [COORD_W-1:0] tbl_x [MAX_POINTS_DEF];
  logic signed [COORD_W-1:0] tbl_y [MAX_POINTS_DEF];
  logic                      tbl_live [MAX_POINTS_DEF];
  logic [DIST_W-1:0]         radius_shadow;

  out_word_t pending_hits[$];

  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int queries_sent = 0;
  int hits_seen = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int long_hold = 0;
  bit timed_out = 1'b0;

  // directed rows, expectations typed in only where obvious
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // updates the shadow table or predicts the hit list of a query
  task automatic predict_pick(input in_word_t w);
    logic [DIST_W-1:0] dist_l [$];
    int                idx_l [$];
    longint            dx;
    longint            dy;
    logic [63:0]       d;
    int                pos;
    out_word_t         o;
    if (w.req_type == REQ_WRITE) begin
      tbl_x[w.entry_index] = w.coord_x;
      tbl_y[w.entry_index] = w.coord_y;
      tbl_live[w.entry_index] = w.entry_present & w.entry_interactable & w.entry_visible;
      return;
    end
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      if (!tbl_live[i]) continue;
      dx = longint'(tbl_x[i]) - longint'(w.coord_x);
      dy = longint'(tbl_y[i]) - longint'(w.coord_y);
      d = floor_root(64'(dx * dx) + 64'(dy * dy));
      if (d > 64'(radius_shadow)) continue;
      // strict compare keeps ties in index order
      pos = dist_l.size();
      while (pos > 0 && 64'(dist_l[pos-1]) > d) pos--;
      dist_l.insert(pos, d[DIST_W-1:0]);
      idx_l.insert(pos, i);
    end
    if (dist_l.size() == 0) begin
      o = '0;
      o.last = 1'b1;
      pending_hits.push_back(o);
      return;
    end
    for (int k = 0; k < dist_l.size() && k < RES_CAP; k++) begin
      o.found = 1'b1;
      o.hit_index = idx_l[k][HIDX_W-1:0];
      o.hit_distance = dist_l[k];
      o.last = (k == dist_l.size() - 1) || (k == RES_CAP - 1);
      pending_hits.push_back(o);
    end
  endtask

  // result side: compare each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (out_data.found) hits_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        out_word_t e;
        e = pending_hits.pop_front();
        if (e.found !== out_data.found || e.hit_index !== out_data.hit_index ||
            e.hit_distance !== out_data.hit_distance || e.last !== out_data.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  // receiver ready, random with an optional long hold-off
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // watchdog on cycles with no accepted word of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offers one word and returns at its accepting edge, valid left for the next caller
  task automatic drive_word(input in_word_t w);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_word(input in_word_t w);
    drive_word(w);
    predict_pick(w);
    words_in++;
    if (w.req_type == REQ_QUERY) queries_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    // a trailing write may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [DIST_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    radius_shadow = r;
  endtask

  function automatic in_word_t make_write(int idx, int x, int y, bit p, bit i, bit v);
    in_word_t w;
    w = '0;
    w.req_type = REQ_WRITE;
    w.entry_index = idx[5:0];
    w.coord_x = x[COORD_W-1:0];
    w.coord_y = y[COORD_W-1:0];
    w.entry_present = p;
    w.entry_interactable = i;
    w.entry_visible = v;
    return w;
  endfunction

  function automatic in_word_t make_query(int x, int y);
    in_word_t w;
    w = '0;
    w.req_type = REQ_QUERY;
    w.coord_x = x[COORD_W-1:0];
    w.coord_y = y[COORD_W-1:0];
    w.entry_index = 6'($urandom);
    w.entry_present = 1'($urandom);
    w.entry_interactable = 1'($urandom);
    w.entry_visible = 1'($urandom);
    return w;
  endfunction

  // random word: mostly writes near a cluster and queries into it, some extremes
  function automatic in_word_t random_word(int spread);
    int cx;
    int cy;
    cx = $urandom_range(2 * spread) - spread;
    cy = $urandom_range(2 * spread) - spread;
    if ($urandom_range(9) < 1) begin
      cx = $urandom;
      cy = $urandom;
    end
    if ($urandom_range(9) < 4)
      return make_write($urandom_range(63), cx, cy, $urandom_range(9) != 0,
                        $urandom_range(9) != 0, $urandom_range(9) != 0);
    return make_query(cx, cy);
  endfunction

  stim_row_t rows[$];

  initial begin
    stim_row_t r;
    out_word_t empty_hit;
    for (int i = 0; i < MAX_POINTS_DEF; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_live[i] = 1'b0;
    end
    radius_shadow = RADIUS_RESET;
    empty_hit = '0;
    empty_hit.last = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    r.typed = 1'b1; r.want = empty_hit;
    r.w = make_query(0, 0);                              rows.push_back(r);
    r.w = make_query(-8388608, 8388607);                 rows.push_back(r);
    r.typed = 1'b0;
    r.w = make_write(0, 0, 0, 1, 1, 1);                  rows.push_back(r);
    r.w = make_write(63, 2560, 0, 1, 1, 1);              rows.push_back(r);
    r.w = make_write(5, 0, 2560, 1, 1, 1);               rows.push_back(r);
    r.w = make_write(6, 100, 100, 0, 1, 1);              rows.push_back(r);
    r.w = make_write(7, 100, 100, 1, 0, 1);              rows.push_back(r);
    r.w = make_write(8, 100, 100, 1, 1, 0);              rows.push_back(r);
    r.w = make_write(9, 2561, 0, 1, 1, 1);               rows.push_back(r);
    r.w = make_query(0, 0);                              rows.push_back(r);
    r.w = make_query(1280, 1280);                        rows.push_back(r);
    r.w = make_write(10, 8388607, 8388607, 1, 1, 1);     rows.push_back(r);
    r.w = make_write(11, -8388608, -8388608, 1, 1, 1);   rows.push_back(r);
    r.w = make_query(8388607, 8388607);                  rows.push_back(r);
    r.w = make_query(-8388608, -8388608);                rows.push_back(r);
    r.typed = 1'b1;
    r.w = make_query(4000000, -4000000);                 rows.push_back(r);

    sender_idle_pct = 18;
    receiver_idle_pct = 88;
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        pending_hits.push_back(rows[i].want);
        words_in++;
        queries_sent++;
        // typed rows carry their own expectation, so skip the predictor
        drive_word(rows[i].w);
      end else begin
        send_word(rows[i].w);
      end
    end
    drain_results();

    // radius extremes: zero only hits exact matches, maximum hits everything
    write_radius('0);
    send_word(make_query(0, 0));
    send_word(make_query(2560, 0));
    drain_results();
    write_radius('1);
    send_word(make_query(0, 0));
    send_word(make_query(8388607, -8388608));
    drain_results();

    // fill all 64 entries near one spot so the cap and ties are reached
    write_radius(24'd4000);
    for (int i = 0; i < MAX_POINTS_DEF; i++)
      send_word(make_write(i, $urandom_range(600) - 300, $urandom_range(4) * 100, 1, 1, 1));
    // receiver holds off while queries pile up behind the block
    long_hold = 3000;
    for (int i = 0; i < 4; i++) send_word(make_query(0, 0));
    drain_results();

    // random phases with three idling profiles and several radius settings
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 88 : 0;
      receiver_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 18 : 0;
      write_radius(ph == 0 ? 24'd2560 : ph == 1 ? 24'($urandom_range(20000)) : 24'd600);
      for (int i = 0; i < NUM_RANDOM / 3; i++) send_word(random_word(3000));
      // sender pauses until everything is back
      drain_results();
    end

    if (pending_hits.size() != 0) mismatches++;
    $display("covered %0d input words, %0d queries, %0d result words, %0d hits",
             words_in, queries_sent, words_out, hits_seen);
    $display("radius zero, maximum and random settings, full table with long output stall");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
